>>> rtl/llp_pkg.sv
// ----------------------------------------------------------------------------
// llp_pkg
// Shared constants, result and operation codes, and the controller/datapath
// command and status bundles of the LL(1) predictive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package llp_pkg;

  // Default sizing
  localparam int STACK_DEPTH_DEF      = 128;
  localparam int MAX_RULES_DEF        = 32;
  localparam int RULE_LEN_DEF         = 32;
  localparam int NUM_NONTERMINALS_DEF = 8;
  localparam int NUM_TERMINALS_DEF    = 7;
  localparam int MAX_EXPANSIONS_DEF   = 15;

  // Start symbol after reset
  localparam logic [8:0] START_RESET = 9'd263;

  // Item operations
  localparam logic [1:0] OP_RULE  = 2'd0;
  localparam logic [1:0] OP_TABLE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_TOKEN = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_RULE     = 3'd0;
  localparam logic [2:0] KIND_MATCH    = 3'd1;
  localparam logic [2:0] KIND_ACCEPT   = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_NORULE   = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW = 3'd5;
  localparam logic [2:0] KIND_DONE     = 3'd6;

  // Configuration register byte addresses
  localparam logic [2:0] ADDR_START_SYMBOL = 3'd0;

  typedef struct packed {
    logic       accept;       // latch item, perform load or start
    logic       pop;          // drop matched terminal
    logic       clr_active;   // end the parse
    logic       rd_top;       // read top of stack
    logic       rd_table;     // read parse table
    logic       sweep_start;  // begin walking the rule right side
    logic       sweep_run;    // advance the walk
    logic       commit;       // take the new stack count
    logic       exp_inc;      // count one expansion
    logic       emit;         // load the result register
    logic [2:0] kind;
    logic       last;
    logic       rule_en;      // report the applied rule number
  } llp_cmd_t;

  typedef struct packed {
    logic clr_busy;
    logic out_free;
    logic in_is_token;
    logic active;
    logic count_zero;
    logic tok_end;
    logic top_term;
    logic top_eq;
    logic nt_ok;
    logic hit;
    logic exp_limit;
    logic sweep_done;
    logic fits;
  } llp_sts_t;

endpackage

`default_nettype wire

>>> rtl/llp_ctrl.sv
// ----------------------------------------------------------------------------
// llp_ctrl
// Parser sequencer: steps each token through stack read, table lookup, rule
// walk and result emission; load and start items emit a done result.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_rdy,
  input  wire llp_pkg::llp_sts_t sts,
  output llp_pkg::llp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DONE, S_TOK, S_TOP, S_TBL, S_SWEEP, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_rdy    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (!sts.clr_busy) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_is_token ? S_TOK : S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = llp_pkg::KIND_DONE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TOK: begin
        if (sts.out_free) begin
          if (!sts.active) begin
            cmd.emit  = 1'b1;
            cmd.kind  = llp_pkg::KIND_MISMATCH;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end else if (sts.count_zero) begin
            cmd.emit       = 1'b1;
            cmd.kind       = sts.tok_end ? llp_pkg::KIND_ACCEPT : llp_pkg::KIND_MISMATCH;
            cmd.last       = 1'b1;
            cmd.clr_active = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.rd_top = 1'b1;
            state_nxt  = S_TOP;
          end
        end
      end
      S_TOP: begin
        if (sts.out_free) begin
          if (sts.top_term) begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            if (sts.top_eq) begin
              cmd.pop  = 1'b1;
              cmd.kind = llp_pkg::KIND_MATCH;
            end else begin
              cmd.clr_active = 1'b1;
              cmd.kind       = llp_pkg::KIND_MISMATCH;
            end
            state_nxt = S_IDLE;
          end else if (!sts.nt_ok) begin
            cmd.emit       = 1'b1;
            cmd.kind       = llp_pkg::KIND_NORULE;
            cmd.last       = 1'b1;
            cmd.clr_active = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.rd_table = 1'b1;
            state_nxt    = S_TBL;
          end
        end
      end
      S_TBL: begin
        if (sts.out_free) begin
          if (!sts.hit || sts.exp_limit) begin
            cmd.emit       = 1'b1;
            cmd.kind       = sts.hit ? llp_pkg::KIND_OVERFLOW : llp_pkg::KIND_NORULE;
            cmd.last       = 1'b1;
            cmd.clr_active = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.sweep_start = 1'b1;
            state_nxt       = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (sts.sweep_done) state_nxt = S_FIN;
        else cmd.sweep_run = 1'b1;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.fits) begin
            cmd.commit  = 1'b1;
            cmd.exp_inc = 1'b1;
            cmd.kind    = llp_pkg::KIND_RULE;
            cmd.rule_en = 1'b1;
            state_nxt   = S_TOK;
          end else begin
            cmd.kind       = llp_pkg::KIND_OVERFLOW;
            cmd.last       = 1'b1;
            cmd.clr_active = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/llp_dp.sv
// ----------------------------------------------------------------------------
// llp_dp
// Parser datapath: rule store, parse table, symbol stack, counters, clearing
// pass and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module llp_dp #(
  parameter int STACK_DEPTH      = llp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RULES        = llp_pkg::MAX_RULES_DEF,
  parameter int RULE_LEN         = llp_pkg::RULE_LEN_DEF,
  parameter int NUM_NONTERMINALS = llp_pkg::NUM_NONTERMINALS_DEF,
  parameter int NUM_TERMINALS    = llp_pkg::NUM_TERMINALS_DEF,
  parameter int MAX_EXPANSIONS   = llp_pkg::MAX_EXPANSIONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       in_tdata,
  input  wire logic [8:0]        start_symbol,
  input  wire llp_pkg::llp_cmd_t cmd,
  output llp_pkg::llp_sts_t      sts,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,
  output logic                   out_tlast
);

  localparam int RULE_DEPTH = MAX_RULES * RULE_LEN;
  localparam int TBL_DEPTH  = NUM_NONTERMINALS * NUM_TERMINALS;
  localparam int CLR_DEPTH  = (RULE_DEPTH > TBL_DEPTH) ? RULE_DEPTH : TBL_DEPTH;
  localparam int RA_W  = $clog2(RULE_DEPTH);
  localparam int TA_W  = $clog2(TBL_DEPTH);
  localparam int EN_W  = $clog2(MAX_RULES) + 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int PTR_W = $clog2(STACK_DEPTH + RULE_LEN + 1);
  localparam int COL_W = $clog2(RULE_LEN);
  localparam int EXP_W = $clog2(MAX_EXPANSIONS + 1);
  localparam int CLR_W = $clog2(CLR_DEPTH + 1);

  // Item fields
  logic [1:0]  in_op;
  logic [3:0]  in_tok;
  logic [4:0]  in_row, in_col;
  logic [9:0]  in_val;
  assign in_op  = in_tdata[1:0];
  assign in_tok = in_tdata[5:2];
  assign in_row = in_tdata[10:6];
  assign in_col = in_tdata[15:11];
  assign in_val = in_tdata[25:16];

  // Stores
  logic [9:0]      rule_mem [RULE_DEPTH];
  logic [EN_W-1:0] tbl_mem  [TBL_DEPTH];
  logic [8:0]      stk_mem  [STACK_DEPTH];

  logic [9:0]       rule_rd_r;
  logic [EN_W-1:0]  tbl_rd_r;
  logic [8:0]       top_r;
  logic [CLR_W-1:0] clr_cnt_r;
  logic             clr_busy_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             active_r;
  logic [3:0]       tok_r;
  logic [EXP_W-1:0] exp_r;
  logic [PTR_W-1:0] ptr_r;
  logic [COL_W-1:0] col_r;
  logic             pend_r;
  logic             out_valid_r;
  logic [15:0]      out_data_r;
  logic             out_last_r;

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  // Rule store: clear, load, and one read per cycle during the walk
  logic            rule_we;
  logic [RA_W-1:0] rule_wa, rule_ra;
  logic [9:0]      rule_wd;
  logic            rule_re;
  logic [COL_W-1:0] rd_col;

  assign rd_col  = cmd.sweep_start ? COL_W'(RULE_LEN - 1) : col_r;
  assign rule_re = cmd.sweep_start || (cmd.sweep_run && col_r != '0);
  assign rule_ra = RA_W'(32'(tbl_rd_r[EN_W-2:0]) * RULE_LEN + 32'(rd_col));

  always_comb begin
    rule_we = 1'b0;
    rule_wa = RA_W'(clr_cnt_r);
    rule_wd = '1;
    if (clr_busy_r) begin
      rule_we = (32'(clr_cnt_r) < RULE_DEPTH);
    end else if (cmd.accept && in_op == llp_pkg::OP_RULE) begin
      rule_we = (32'(in_row) < MAX_RULES) && (32'(in_col) < RULE_LEN);
      rule_wa = RA_W'(32'(in_row) * RULE_LEN + 32'(in_col));
      rule_wd = in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    if (rule_re) rule_rd_r <= rule_mem[rule_ra];
  end

  // Parse table; out-of-range rule numbers are stored as a miss
  logic            tbl_we;
  logic [TA_W-1:0] tbl_wa, tbl_ra;
  logic [EN_W-1:0] tbl_wd;

  assign tbl_ra = TA_W'(32'(top_r[7:0]) * NUM_TERMINALS + 32'(tok_r));

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = TA_W'(clr_cnt_r);
    tbl_wd = '1;
    if (clr_busy_r) begin
      tbl_we = (32'(clr_cnt_r) < TBL_DEPTH);
    end else if (cmd.accept && in_op == llp_pkg::OP_TABLE) begin
      tbl_we = (32'(in_row) < NUM_NONTERMINALS) && (32'(in_col) < NUM_TERMINALS);
      tbl_wa = TA_W'(32'(in_row) * NUM_TERMINALS + 32'(in_col));
      if (!in_val[9] && 32'(in_val[8:0]) < MAX_RULES)
        tbl_wd = {1'b0, (EN_W-1)'(in_val[8:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (cmd.rd_table) tbl_rd_r <= tbl_mem[tbl_ra];
  end

  // Symbol stack: start push or right-side push; slots past the top are scratch
  logic            stk_we;
  logic [SA_W-1:0] stk_wa;
  logic [8:0]      stk_wd;
  logic            push_sym;

  assign push_sym = cmd.sweep_run && pend_r && !rule_rd_r[9] && rule_rd_r != '0;

  always_comb begin
    stk_we = 1'b0;
    stk_wa = SA_W'(ptr_r);
    stk_wd = rule_rd_r[8:0];
    if (cmd.accept && in_op == llp_pkg::OP_START) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = start_symbol;
    end else if (push_sym) begin
      stk_we = (ptr_r < PTR_W'(STACK_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (cmd.rd_top) top_r <= stk_mem[SA_W'(count_r - 1'b1)];
  end

  // Counters and walk state
  always_comb begin
    count_nxt = count_r;
    if (cmd.accept && in_op == llp_pkg::OP_START) count_nxt = CNT_W'(1);
    else if (cmd.pop) count_nxt = count_r - 1'b1;
    else if (cmd.commit) count_nxt = CNT_W'(ptr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      exp_r    <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.accept && in_op == llp_pkg::OP_START) active_r <= 1'b1;
      else if (cmd.clr_active) active_r <= 1'b0;
      if (cmd.accept) exp_r <= '0;
      else if (cmd.exp_inc) exp_r <= exp_r + 1'b1;
      if (cmd.sweep_start) pend_r <= 1'b1;
      else if (cmd.sweep_run) pend_r <= (col_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) tok_r <= in_tok;
    if (cmd.sweep_start) begin
      ptr_r <= PTR_W'(count_r - 1'b1);
      col_r <= COL_W'(RULE_LEN - 2);
    end else if (cmd.sweep_run) begin
      if (push_sym) ptr_r <= ptr_r + 1'b1;
      if (col_r != '0) col_r <= col_r - 1'b1;
    end
  end

  // Result register
  logic [4:0] rule_num;
  assign rule_num = cmd.rule_en ? 5'(tbl_rd_r[EN_W-2:0]) : 5'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {8'(count_nxt), rule_num, cmd.kind};
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Status
  assign sts.clr_busy    = clr_busy_r;
  assign sts.out_free    = !out_valid_r || out_tready;
  assign sts.in_is_token = (in_op == llp_pkg::OP_TOKEN);
  assign sts.active      = active_r;
  assign sts.count_zero  = (count_r == '0);
  assign sts.tok_end     = (tok_r == 4'd0);
  assign sts.top_term    = (32'(top_r) < NUM_TERMINALS);
  assign sts.top_eq      = (top_r == 9'(tok_r));
  assign sts.nt_ok       = top_r[8] && (32'(top_r[7:0]) < NUM_NONTERMINALS)
                           && (32'(tok_r) < NUM_TERMINALS);
  assign sts.hit         = !tbl_rd_r[EN_W-1];
  assign sts.exp_limit   = (exp_r >= EXP_W'(MAX_EXPANSIONS));
  assign sts.sweep_done  = !pend_r;
  assign sts.fits        = (ptr_r <= PTR_W'(STACK_DEPTH));

endmodule

`default_nettype wire

>>> rtl/ll1_predictive_parser_unit.sv
// ----------------------------------------------------------------------------
// ll1_predictive_parser_unit
// Table-driven LL(1) predictive parser with loadable rule store and parse
// table, a symbol stack, and a result stream of one or more items per input.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata: opcode, token, row_index, col_index, load_value
//  out_    | master    | tdata: kind, rule_number, depth_now; tlast: last
//  cfg_    | APB slave | start_symbol at byte address 0
//
// Load and start items end in a done result. A token is matched or rejected,
// the reject depending on where the check falls, or expanded through a table
// lookup and a rule walk; the expansion walks the rule right side one stored
// symbol a cycle through the single rule-store read port. After reset a
// clearing pass over the larger of the rule store and the table writes -1
// over both stores; no item is taken then.
// A stalled result register holds the sequencer until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1_predictive_parser_unit #(
  parameter int STACK_DEPTH      = llp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RULES        = llp_pkg::MAX_RULES_DEF,
  parameter int RULE_LEN         = llp_pkg::RULE_LEN_DEF,
  parameter int NUM_NONTERMINALS = llp_pkg::NUM_NONTERMINALS_DEF,
  parameter int NUM_TERMINALS    = llp_pkg::NUM_TERMINALS_DEF,
  parameter int MAX_EXPANSIONS   = llp_pkg::MAX_EXPANSIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] opcode, [5:2] token, [10:6] row_index, [15:11] col_index,
  // [25:16] load_value, [31:26] zero
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] kind, [7:3] rule_number, [15:8] depth_now
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  llp_pkg::llp_cmd_t cmd;
  llp_pkg::llp_sts_t sts;
  logic [8:0]        start_symbol_r;

  // Configuration: single register, writes complete in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == llp_pkg::ADDR_START_SYMBOL) ?
                      {23'd0, start_symbol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_symbol_r <= llp_pkg::START_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == llp_pkg::ADDR_START_SYMBOL) begin
      start_symbol_r <= cfg_pwdata[8:0];
    end
  end

  // Sequencer
  llp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_rdy    (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores, stack and result register
  llp_dp #(
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_RULES        (MAX_RULES),
    .RULE_LEN         (RULE_LEN),
    .NUM_NONTERMINALS (NUM_NONTERMINALS),
    .NUM_TERMINALS    (NUM_TERMINALS),
    .MAX_EXPANSIONS   (MAX_EXPANSIONS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .start_symbol (start_symbol_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

`default_nettype wire
